@@ src/rld_pkg.sv @@
// ----------------------------------------------------------------------------
// rld_pkg
// Shared constants and types for the run-list decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rld_pkg;

    // Largest accepted length or offset field, in bytes.
    localparam int FIELD_BYTES = 4;

    // Header nibble mask, the sign bit of a field byte and the sign fill byte.
    localparam logic [7:0] NIBBLE_MASK = 8'h0f;
    localparam logic [7:0] SIGN_MASK   = 8'h80;
    localparam logic [7:0] FILL_BYTE   = 8'hff;

    // Parse phase codes.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_OFF  = 2'd2;

    typedef struct packed {
        logic [1:0]  parse_phase;
        logic [2:0]  bytes_left;
        logic [2:0]  offset_size;
        logic [1:0]  byte_position;
        logic [31:0] length_accum;
        logic [31:0] offset_accum;
        logic [31:0] current_cluster;
        logic        list_active;
    } rld_state_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] start_cluster;
        logic [31:0] cluster_count;
        logic        sparse;
        logic        list_end;
        logic        size_error;
    } rld_result_t;

endpackage

`default_nettype wire

@@ src/rld_step.sv @@
// ----------------------------------------------------------------------------
// rld_step
// One-byte parse step: next parser state and the optional run result.
// ----------------------------------------------------------------------------
`default_nettype none

module rld_step (
    input  wire logic [7:0]          run_byte,
    input  wire logic                first_of_list,
    input  wire rld_pkg::rld_state_t state_cur,
    output rld_pkg::rld_state_t      state_next,
    output rld_pkg::rld_result_t     result
);

    logic [3:0]  len_size;
    logic [3:0]  off_size;
    logic [31:0] placed;
    logic [2:0]  left_dec;

    assign len_size = 4'(run_byte & rld_pkg::NIBBLE_MASK);
    assign off_size = 4'((run_byte >> 4) & rld_pkg::NIBBLE_MASK);
    assign placed   = 32'(run_byte) << {state_cur.byte_position, 3'b000};
    assign left_dec = (state_cur.bytes_left != 3'd0) ? state_cur.bytes_left - 3'd1
                                                     : 3'd0;

    always_comb
    begin
        logic [31:0] off_acc;
        state_next = state_cur;
        result     = '0;
        off_acc    = '0;

        if (first_of_list)
        begin
            state_next.current_cluster = '0;
            state_next.list_active     = 1'b1;
            state_next.parse_phase     = rld_pkg::PH_IDLE;
        end

        if (state_next.list_active)
        begin
            unique case (state_next.parse_phase)
                rld_pkg::PH_IDLE:
                begin
                    if (run_byte == 8'd0)
                    begin
                        state_next.list_active = 1'b0;
                        result.valid           = 1'b1;
                        result.list_end        = 1'b1;
                    end
                    else if (len_size > 4'(rld_pkg::FIELD_BYTES) ||
                             off_size > 4'(rld_pkg::FIELD_BYTES))
                    begin
                        state_next.list_active = 1'b0;
                        result.valid           = 1'b1;
                        result.size_error      = 1'b1;
                    end
                    else
                    begin
                        state_next.length_accum  = '0;
                        state_next.offset_accum  = '0;
                        state_next.offset_size   = off_size[2:0];
                        state_next.byte_position = '0;
                        if (len_size != 4'd0)
                        begin
                            state_next.parse_phase = rld_pkg::PH_LEN;
                            state_next.bytes_left  = len_size[2:0];
                        end
                        else if (off_size != 4'd0)
                        begin
                            state_next.parse_phase = rld_pkg::PH_OFF;
                            state_next.bytes_left  = off_size[2:0];
                        end
                        else
                        begin
                            // empty header fields: sparse run of zero length
                            result.valid  = 1'b1;
                            result.sparse = 1'b1;
                        end
                    end
                end

                rld_pkg::PH_LEN:
                begin
                    state_next.length_accum  = state_cur.length_accum | placed;
                    state_next.byte_position = state_cur.byte_position + 2'd1;
                    state_next.bytes_left    = left_dec;
                    if (left_dec == 3'd0)
                    begin
                        state_next.byte_position = '0;
                        if (state_cur.offset_size == 3'd0)
                        begin
                            state_next.parse_phase = rld_pkg::PH_IDLE;
                            result.valid         = 1'b1;
                            result.sparse        = 1'b1;
                            result.cluster_count = state_next.length_accum;
                        end
                        else
                        begin
                            state_next.parse_phase = rld_pkg::PH_OFF;
                            state_next.bytes_left  = state_cur.offset_size;
                        end
                    end
                end

                default:
                begin
                    // offset phase (the unused phase code lands here too)
                    off_acc = state_cur.offset_accum | placed;
                    state_next.byte_position = state_cur.byte_position + 2'd1;
                    state_next.bytes_left    = left_dec;
                    if (left_dec == 3'd0)
                    begin
                        if ((run_byte & rld_pkg::SIGN_MASK) != 8'd0)
                        begin
                            for (int k = 0; k < 4; k++)
                            begin
                                if (3'(k) >= state_cur.offset_size)
                                    off_acc[8*k +: 8] = rld_pkg::FILL_BYTE;
                            end
                        end
                        state_next.current_cluster = state_cur.current_cluster + off_acc;
                        state_next.parse_phase     = rld_pkg::PH_IDLE;
                        state_next.byte_position   = '0;
                        result.valid         = 1'b1;
                        result.start_cluster = state_next.current_cluster;
                        result.cluster_count = state_cur.length_accum;
                    end
                    state_next.offset_accum = off_acc;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/runlist_decoder_core.sv @@
// ----------------------------------------------------------------------------
// runlist_decoder_core
// NTFS data-run list decoder, one list byte per request.
// ----------------------------------------------------------------------------
// The block takes one run-list byte per clock cycle, back to back, and gives
// at most one run result per byte. A result shows on the output channel in the
// cycle after the byte that completes it (the closing field byte, a zero
// header or an oversized header) is accepted. The parse step is a single
// pass of logic from the parser state register to the result register; the
// result register alone sets the flow: a new byte is taken whenever that
// register is empty or its result is being taken in the same cycle.
// first_of_list on a byte restarts parsing with a cleared running cluster.
// Bytes outside an active list are dropped without a result.
// ----------------------------------------------------------------------------
`default_nettype none

module runlist_decoder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  run_byte,
    input  wire logic        first_of_list,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      run_start_cluster,
    output logic [31:0]      run_cluster_count,
    output logic             sparse_run,
    output logic             list_end,
    output logic             size_error
);

    rld_pkg::rld_state_t  st_reg;
    rld_pkg::rld_state_t  st_next;
    rld_pkg::rld_result_t res_next;

    logic        out_valid_reg;
    logic [31:0] start_reg;
    logic [31:0] count_reg;
    logic        sparse_reg;
    logic        end_reg;
    logic        err_reg;
    logic        in_take;

    // Result slot free now or emptied this cycle.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_take  = in_valid && in_ready;

    rld_step u_step (
        .run_byte      (run_byte),
        .first_of_list (first_of_list),
        .state_cur     (st_reg),
        .state_next    (st_next),
        .result        (res_next)
    );

    // Parser state advances on every accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (in_take)
            st_reg <= st_next;
    end

    // Output valid: drop on take, set when an accepted byte yields a run.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (in_take && res_next.valid)
                out_valid_reg <= 1'b1;
        end
    end

    // Result payload, no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_take && res_next.valid)
        begin
            start_reg  <= res_next.start_cluster;
            count_reg  <= res_next.cluster_count;
            sparse_reg <= res_next.sparse;
            end_reg    <= res_next.list_end;
            err_reg    <= res_next.size_error;
        end
    end

    assign out_valid         = out_valid_reg;
    assign run_start_cluster = start_reg;
    assign run_cluster_count = count_reg;
    assign sparse_run        = sparse_reg;
    assign list_end          = end_reg;
    assign size_error        = err_reg;

`ifndef SYNTHESIS
    // At most one special-case flag per result.
    a_flags_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({sparse_run, list_end, size_error}))
        else $error("more than one result flag set");

    // End marker and size error carry zero cluster fields.
    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (list_end || size_error)) |->
        (run_start_cluster == 32'd0 && run_cluster_count == 32'd0))
        else $error("marker result with nonzero cluster fields");

    // Sparse runs have no start cluster.
    a_sparse_start: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sparse_run) |-> (run_start_cluster == 32'd0))
        else $error("sparse run with nonzero start cluster");

    // A byte outside any list leaves the result slot empty.
    a_idle_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && !first_of_list && !st_reg.list_active) |=> !out_valid)
        else $error("result from a byte outside a list");
`endif

endmodule

`default_nettype wire
